@@ rtl/rht_pkg.sv @@
// ----------------------------------------------------------------------------
// rht_pkg
// Shared types, sizes and codes for the reference-counted handle table.
// ----------------------------------------------------------------------------
package rht_pkg;

    localparam int unsigned DEPTH = 128;
    localparam int unsigned AW    = $clog2(DEPTH);      // entry index width
    localparam int unsigned CW    = $clog2(DEPTH + 1);  // occupancy width

    localparam int unsigned IN_W  = 88;  // 82 payload bits, byte padded
    localparam int unsigned OUT_W = 56;

    // commands
    localparam logic [2:0] CMD_ACQ  = 3'd0;
    localparam logic [2:0] CMD_REL  = 3'd1;
    localparam logic [2:0] CMD_RBND = 3'd2;
    localparam logic [2:0] CMD_ANON = 3'd3;
    localparam logic [2:0] CMD_QRY  = 3'd4;

    // result status codes
    localparam logic [3:0] ST_HIT      = 4'd0;
    localparam logic [3:0] ST_INSERTED = 4'd1;
    localparam logic [3:0] ST_FULL     = 4'd2;
    localparam logic [3:0] ST_FREED    = 4'd3;
    localparam logic [3:0] ST_DECR     = 4'd4;
    localparam logic [3:0] ST_NOTFOUND = 4'd5;
    localparam logic [3:0] ST_NULL     = 4'd6;
    localparam logic [3:0] ST_REBOUND  = 4'd7;
    localparam logic [3:0] ST_IGNORED  = 4'd8;
    localparam logic [3:0] ST_COUNT    = 4'd9;

    // entry write selects
    localparam logic [2:0] WR_NONE   = 3'd0;
    localparam logic [2:0] WR_BUMP   = 3'd1;
    localparam logic [2:0] WR_DEC    = 3'd2;
    localparam logic [2:0] WR_REBIND = 3'd3;
    localparam logic [2:0] WR_APPEND = 3'd4;
    localparam logic [2:0] WR_MOVE   = 3'd5;

    localparam logic [15:0] ANON_ID   = 16'hFFFF;
    localparam logic [7:0]  SLOT_NONE = 8'(DEPTH);

    typedef struct packed {
        logic [15:0] obj_id;
        logic [31:0] handle;
        logic [7:0]  refs;
    } t_entry;

    localparam int unsigned EW = $bits(t_entry);

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       scan_init;
        logic       scan_step;
        logic       rd_last;
        logic [2:0] wr_sel;
        logic       res_we;
        logic [3:0] res_st;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       h_null;
        logic       rebind_bad;
        logic       hit;
        logic       miss;
        logic       refs_le1;
        logic       full;
        logic       out_free;
    } t_sts;

endpackage

@@ rtl/rht_ram.sv @@
// ----------------------------------------------------------------------------
// rht_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rht_ram #(
    parameter int unsigned W = 8,
    parameter int unsigned D = 16,
    localparam int unsigned A = $clog2(D)
) (
    input  logic         i_clk,
    input  logic         i_we,
    input  logic [A-1:0] i_waddr,
    input  logic [W-1:0] i_wdata,
    input  logic         i_re,
    input  logic [A-1:0] i_raddr,
    output logic [W-1:0] o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rht_ctrl.sv @@
// ----------------------------------------------------------------------------
// rht_ctrl
// Command sequencer: decode, scan, entry update and result handoff.
// ----------------------------------------------------------------------------
module rht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rht_pkg::t_sts i_sts,
    output rht_pkg::t_ctl o_ctl
);
    import rht_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_ACT  = 4'd3;
    localparam logic [3:0] S_MISS = 4'd4;
    localparam logic [3:0] S_APP  = 4'd5;
    localparam logic [3:0] S_FRD  = 4'd6;
    localparam logic [3:0] S_FWR  = 4'd7;
    localparam logic [3:0] S_RESP = 4'd8;

    logic [3:0] r_state, n_state;
    logic [3:0] r_st, n_st;

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_ctl   = '0;
        o_ctl.wr_sel = WR_NONE;
        o_ctl.res_st = r_st;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_ctl.scan_init = 1'b1;
                priority case (i_sts.cmd)
                    CMD_ACQ, CMD_QRY: n_state = S_SCAN;
                    CMD_REL: begin
                        if (i_sts.h_null) begin
                            n_st = ST_NULL;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    CMD_RBND: begin
                        if (i_sts.rebind_bad) begin
                            n_st = ST_IGNORED;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    CMD_ANON: n_state = S_APP;
                    default: begin
                        n_st = ST_IGNORED;
                        n_state = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_ACT;
                end else if (i_sts.miss) begin
                    n_state = S_MISS;
                end
            end
            S_ACT: begin
                n_state = S_RESP;
                priority case (i_sts.cmd)
                    CMD_ACQ: begin
                        o_ctl.wr_sel = WR_BUMP;
                        n_st = ST_HIT;
                    end
                    CMD_REL: begin
                        if (i_sts.refs_le1) begin
                            n_state = S_FRD;
                        end else begin
                            o_ctl.wr_sel = WR_DEC;
                            n_st = ST_DECR;
                        end
                    end
                    CMD_RBND: begin
                        o_ctl.wr_sel = WR_REBIND;
                        n_st = ST_REBOUND;
                    end
                    default: n_st = ST_COUNT;
                endcase
            end
            S_MISS: begin
                n_state = S_RESP;
                priority case (i_sts.cmd)
                    CMD_ACQ: n_state = S_APP;
                    CMD_QRY: n_st = ST_COUNT;
                    default: n_st = ST_NOTFOUND;
                endcase
            end
            S_APP: begin
                n_state = S_RESP;
                if (i_sts.full) begin
                    n_st = ST_FULL;
                end else begin
                    o_ctl.wr_sel = WR_APPEND;
                    n_st = ST_INSERTED;
                end
            end
            S_FRD: begin
                o_ctl.rd_last = 1'b1;
                n_state = S_FWR;
            end
            S_FWR: begin
                o_ctl.wr_sel = WR_MOVE;
                n_st = ST_FREED;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_ctl.res_we = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_IGNORED;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

endmodule

@@ rtl/rht_dp.sv @@
// ----------------------------------------------------------------------------
// rht_dp
// Datapath: command registers, entry RAM, scan pointer, occupancy, result reg.
// ----------------------------------------------------------------------------
module rht_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [rht_pkg::IN_W-1:0]  i_in_data,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [rht_pkg::OUT_W-1:0] o_out_data,
    input  rht_pkg::t_ctl             i_ctl,
    output rht_pkg::t_sts             o_sts
);
    import rht_pkg::*;

    logic [2:0]    r_cmd;
    logic [14:0]   r_id;
    logic [31:0]   r_h;
    logic [31:0]   r_nh;
    logic [CW-1:0] r_occ;
    logic [CW-1:0] r_ridx;
    logic          r_pv;
    logic [AW-1:0] r_pidx;
    logic [AW-1:0] r_fidx;
    logic          r_found;
    t_entry        r_ent;

    logic          r_ov;
    logic [3:0]    r_o_st;
    logic [31:0]   r_o_h;
    logic [7:0]    r_o_rc;
    logic [7:0]    r_o_slot;

    t_entry        rd_ent;
    logic [EW-1:0] rd_data;
    logic          key_eq;
    logic          hit;
    logic          scan_more;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        wr_ent;
    logic [CW-1:0] occ_m1;
    logic [7:0]    refs_inc;

    assign rd_ent    = t_entry'(rd_data);
    assign occ_m1    = r_occ - CW'(1);
    assign scan_more = r_ridx < r_occ;
    assign refs_inc  = (r_ent.refs == 8'hFF) ? 8'hFF : r_ent.refs + 8'd1;

    // id commands match the asset id, the rest match the stored handle
    assign key_eq = (r_cmd == CMD_ACQ || r_cmd == CMD_QRY)
                  ? (rd_ent.obj_id == {1'b0, r_id})
                  : (rd_ent.handle == r_h);
    assign hit = r_pv && key_eq;

    assign ram_re    = (i_ctl.scan_step && scan_more) || i_ctl.rd_last;
    assign ram_raddr = i_ctl.rd_last ? occ_m1[AW-1:0] : r_ridx[AW-1:0];
    assign ram_we    = (i_ctl.wr_sel != WR_NONE);
    assign ram_waddr = (i_ctl.wr_sel == WR_APPEND) ? r_occ[AW-1:0] : r_fidx;

    always_comb begin
        wr_ent = r_ent;
        unique case (i_ctl.wr_sel)
            WR_BUMP:   wr_ent.refs = refs_inc;
            WR_DEC:    wr_ent.refs = r_ent.refs - 8'd1;
            WR_REBIND: wr_ent.handle = r_nh;
            WR_APPEND: begin
                wr_ent.obj_id = (r_cmd == CMD_ACQ) ? {1'b0, r_id} : ANON_ID;
                wr_ent.handle = r_nh;
                wr_ent.refs   = 8'd1;
            end
            WR_MOVE:   wr_ent = rd_ent;
            default:   wr_ent = r_ent;
        endcase
    end

    rht_ram #(
        .W(EW),
        .D(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_ent),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_in_data[2:0];
            r_id  <= i_in_data[17:3];
            r_h   <= i_in_data[49:18];
            r_nh  <= i_in_data[81:50];
        end
        if (i_ctl.scan_step) begin
            r_pidx <= r_ridx[AW-1:0];
            if (hit) begin
                r_ent  <= rd_ent;
                r_fidx <= r_pidx;
            end
        end
        if (i_ctl.wr_sel == WR_APPEND) begin
            r_fidx <= r_occ[AW-1:0];
        end
        if (i_ctl.res_we) begin
            r_o_st   <= i_ctl.res_st;
            r_o_h    <= 32'd0;
            r_o_rc   <= 8'd0;
            r_o_slot <= SLOT_NONE;
            unique case (i_ctl.res_st)
                ST_HIT: begin
                    r_o_h    <= r_ent.handle;
                    r_o_rc   <= refs_inc;
                    r_o_slot <= 8'(r_fidx);
                end
                ST_INSERTED: begin
                    r_o_h    <= r_nh;
                    r_o_rc   <= 8'd1;
                    r_o_slot <= 8'(r_fidx);
                end
                ST_FREED: begin
                    r_o_h    <= r_h;
                    r_o_slot <= 8'(r_fidx);
                end
                ST_DECR: begin
                    r_o_rc   <= r_ent.refs - 8'd1;
                    r_o_slot <= 8'(r_fidx);
                end
                ST_REBOUND: begin
                    r_o_rc   <= r_ent.refs;
                    r_o_slot <= 8'(r_fidx);
                end
                ST_COUNT: begin
                    if (r_found) begin
                        r_o_rc   <= r_ent.refs;
                        r_o_slot <= 8'(r_fidx);
                    end
                end
                default: begin
                    r_o_slot <= SLOT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_ridx  <= '0;
            r_pv    <= 1'b0;
            r_found <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_ctl.scan_init) begin
                r_ridx  <= '0;
                r_pv    <= 1'b0;
                r_found <= 1'b0;
            end else if (i_ctl.scan_step) begin
                r_pv <= scan_more;
                if (scan_more) begin
                    r_ridx <= r_ridx + CW'(1);
                end
                if (hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_ctl.wr_sel == WR_APPEND) begin
                r_occ <= r_occ + CW'(1);
            end else if (i_ctl.wr_sel == WR_MOVE) begin
                r_occ <= occ_m1;
            end
            if (i_ctl.res_we) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_sts.cmd        = r_cmd;
    assign o_sts.h_null     = (r_h == 32'd0);
    assign o_sts.rebind_bad = (r_h == 32'd0) || (r_nh == 32'd0) || (r_h == r_nh);
    assign o_sts.hit        = hit;
    assign o_sts.miss       = !hit && !scan_more;
    assign o_sts.refs_le1   = (r_ent.refs <= 8'd1);
    assign o_sts.full       = (r_occ == CW'(DEPTH));
    assign o_sts.out_free   = !r_ov || i_out_ready;

    assign o_out_valid = r_ov;
    assign o_out_data  = OUT_W'({r_o_slot, r_o_rc, r_o_h, r_o_st});

endmodule

@@ rtl/refcounted_handle_table.sv @@
// ----------------------------------------------------------------------------
// refcounted_handle_table
// Reference-counted directory of asset ids and storage handles.
// ----------------------------------------------------------------------------
// One command in, one result out. Entries live in a single RAM and are found
// by a linear scan, one entry per cycle through the RAM read port. A null
// release, an ignored rebind, an anonymous insert or an unused code skips
// the scan; a miss scans every occupied entry. The next command is taken
// once the current one has placed its result in the output register, even
// while that result is still waiting to be taken. Freeing an entry moves
// the last entry into its slot, so slot numbers of other entries may
// change. Counts saturate at 255. There is no clearing pass after reset:
// only entries below the occupancy count are ever read.
// ----------------------------------------------------------------------------
module refcounted_handle_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input transaction
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [2:0] command, [17:3] obj_id, [49:18] handle, [81:50] new_handle
    input  logic [rht_pkg::IN_W-1:0]   s_tdata,
    // result transaction
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [3:0] status, [35:4] handle_out, [43:36] ref_count, [51:44] slot
    output logic [rht_pkg::OUT_W-1:0]  m_tdata
);
    import rht_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // sequencer: decides the step, datapath does the storage and compares
    rht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    rht_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_tdata),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_out_data  (m_tdata),
        .i_ctl       (ctl),
        .o_sts       (sts)
    );

endmodule

@@ test/tb_refcounted_handle_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_refcounted_handle_table
// Self-checking bench for the reference-counted handle table.
// ----------------------------------------------------------------------------
// Commands go in as stream transactions. A behavioral copy of the directory
// predicts each result when the command is accepted. The result checker
// compares every returned transaction, field by field, with the oldest
// prediction. The run has a directed pass over every command and corner
// case, then count saturation, then a fill to full and a drain, then random
// traffic, which mostly reuses live handles and a small id pool so that hits,
// decrements, frees and rebinds happen often. Both sides stall in random
// bursts, except in some quiet stretches and in the last part of the run.
// ----------------------------------------------------------------------------
module tb_refcounted_handle_table;

    import rht_pkg::*;

    localparam int        CLK_HALF    = 5;
    localparam int        RESET_CYCLES = 12;
    localparam int        IDLE_LIMIT  = 4000;   // cycles with no transaction
    localparam logic [7:0] REFS_MAX   = 8'hFF;

    // one command, packed as it travels in s_tdata (last field in the LSBs)
    typedef struct packed {
        logic [31:0] new_handle;
        logic [31:0] handle;
        logic [14:0] obj_id;
        logic [2:0]  command;
    } t_request;

    // one result, packed as it travels in m_tdata
    typedef struct packed {
        logic [7:0]  slot;
        logic [7:0]  ref_count;
        logic [31:0] handle_out;
        logic [3:0]  status;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    // [2:0] command, [17:3] obj_id, [49:18] handle, [81:50] new_handle
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // [3:0] status, [35:4] handle_out, [43:36] ref_count, [51:44] slot
    logic [OUT_W-1:0]  m_tdata;

    // predicted directory contents
    logic [15:0] dir_asset  [DEPTH];
    logic [31:0] dir_handle [DEPTH];
    logic [7:0]  dir_refs   [DEPTH];
    int          dir_used;

    t_result     pending_results[$];
    int          errors;
    int          idle_pct;      // chance of a gap or a stall, in percent
    int          rx_stall;

    refcounted_handle_table i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Directory predictor
    // ------------------------------------------------------------------
    // Lowest matching index below the occupancy, DEPTH when absent.
    // Anonymous entries carry an id with bit 15 set and never match.
    function automatic int find_by_id(input logic [14:0] id);
        for (int k = 0; k < dir_used; k++)
            if (dir_asset[k] == {1'b0, id})
                return k;
        return DEPTH;
    endfunction

    function automatic int find_by_handle(input logic [31:0] h);
        for (int k = 0; k < dir_used; k++)
            if (dir_handle[k] == h)
                return k;
        return DEPTH;
    endfunction

    task automatic append_entry(input logic [15:0] id, input logic [31:0] h,
                                inout t_result r);
        if (dir_used >= DEPTH) begin
            r.status = ST_FULL;
        end else begin
            dir_asset[dir_used]  = id;
            dir_handle[dir_used] = h;
            dir_refs[dir_used]   = 8'd1;
            r.status     = ST_INSERTED;
            r.handle_out = h;
            r.ref_count  = 8'd1;
            r.slot       = 8'(dir_used);
            dir_used++;
        end
    endtask

    // Applies one accepted command to the directory copy and queues the
    // result it must produce.
    task automatic predict_directory(input t_request rq);
        t_result r;
        int      k;
        int      last;
        r.status     = ST_IGNORED;
        r.handle_out = '0;
        r.ref_count  = '0;
        r.slot       = SLOT_NONE;
        case (rq.command)
            CMD_ACQ: begin
                k = find_by_id(rq.obj_id);
                if (k < DEPTH) begin
                    if (dir_refs[k] != REFS_MAX)
                        dir_refs[k]++;
                    r.status     = ST_HIT;
                    r.handle_out = dir_handle[k];
                    r.ref_count  = dir_refs[k];
                    r.slot       = 8'(k);
                end else begin
                    append_entry({1'b0, rq.obj_id}, rq.new_handle, r);
                end
            end
            CMD_REL: begin
                k = (rq.handle == '0) ? DEPTH : find_by_handle(rq.handle);
                if (rq.handle == '0) begin
                    r.status = ST_NULL;
                end else if (k >= DEPTH) begin
                    r.status = ST_NOTFOUND;
                end else if (dir_refs[k] <= 8'd1) begin
                    // last reference: the last entry moves into the hole
                    last          = dir_used - 1;
                    dir_asset[k]  = dir_asset[last];
                    dir_handle[k] = dir_handle[last];
                    dir_refs[k]   = dir_refs[last];
                    dir_used      = last;
                    r.status      = ST_FREED;
                    r.handle_out  = rq.handle;
                    r.slot        = 8'(k);
                end else begin
                    dir_refs[k]--;
                    r.status    = ST_DECR;
                    r.ref_count = dir_refs[k];
                    r.slot      = 8'(k);
                end
            end
            CMD_RBND: begin
                if (rq.handle != '0 && rq.new_handle != '0 &&
                    rq.handle != rq.new_handle) begin
                    k = find_by_handle(rq.handle);
                    if (k >= DEPTH) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        dir_handle[k] = rq.new_handle;
                        r.status    = ST_REBOUND;
                        r.ref_count = dir_refs[k];
                        r.slot      = 8'(k);
                    end
                end
            end
            CMD_ANON: append_entry(ANON_ID, rq.new_handle, r);
            CMD_QRY: begin
                k = find_by_id(rq.obj_id);
                r.status = ST_COUNT;
                if (k < DEPTH) begin
                    r.ref_count = dir_refs[k];
                    r.slot      = 8'(k);
                end
            end
            default: ;  // spare codes are ignored
        endcase
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Command side: drives at the falling edge, valid stays high between
    // back-to-back commands and is only lowered for a gap or a wait for results.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [2:0] cmd, input logic [14:0] id,
                                input logic [31:0] h, input logic [31:0] nh);
        t_request rq;
        rq.command    = cmd;
        rq.obj_id     = id;
        rq.handle     = h;
        rq.new_handle = nh;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_tdata  <= IN_W'(rq);
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        predict_directory(rq);
        @(negedge i_clk);
    endtask

    // hold the command side until every predicted result has come back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, m_tready low in each of their cycles
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
            rx_stall <= $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                 $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[$bits(t_result)-1:0];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got 0x%0h",
                         $time, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", want.status, got.status);
                if (got.handle_out !== want.handle_out)
                    report_mismatch("handle_out", want.handle_out, got.handle_out);
                if (got.ref_count !== want.ref_count)
                    report_mismatch("ref_count", want.ref_count, got.ref_count);
                if (got.slot !== want.slot)
                    report_mismatch("slot", want.slot, got.slot);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus pickers: a small id pool, and mostly handles that are live in the table
    // ------------------------------------------------------------------
    function automatic logic [14:0] pick_obj_id();
        logic [14:0] k;
        if ($urandom_range(0, 4) == 0)
            return 15'($urandom);
        k = 15'($urandom_range(0, 11));
        return $urandom_range(0, 1) ? ~k : k;   // small pool at both ends
    endfunction

    function automatic logic [31:0] pick_handle();
        if (dir_used > 0 && $urandom_range(0, 3) != 0)
            return dir_handle[$urandom_range(0, dir_used - 1)];
        if ($urandom_range(0, 9) == 0)
            return '0;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_new_handle();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        if (roll < 3 && dir_used > 0)
            return dir_handle[$urandom_range(0, dir_used - 1)];   // duplicate
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every command and corner case on a nearly empty table.
    task automatic test_directed_ops();
        idle_pct = 20;
        send_request(CMD_QRY,  15'd5,      32'h0,          32'h0);          // absent id
        send_request(CMD_REL,  15'd0,      32'h0,          32'h1234);       // null release
        send_request(CMD_REL,  15'd0,      32'h1234,       32'h0);          // absent handle
        send_request(CMD_RBND, 15'd0,      32'h0,          32'h5);          // null old
        send_request(CMD_RBND, 15'd0,      32'h5,          32'h0);          // null new
        send_request(CMD_RBND, 15'd0,      32'h7,          32'h7);          // same handles
        send_request(CMD_ACQ,  15'h0000,   32'h0,          32'hFFFF_FFFF);  // insert slot 0
        send_request(CMD_ACQ,  15'h7FFF,   32'h0,          32'h0000_0001);  // insert slot 1
        send_request(CMD_ACQ,  15'h0000,   32'h0,          32'h0BAD_0BAD);  // hit
        send_request(CMD_ANON, 15'h7FFF,   32'h0,          32'hA5A5_A5A5);  // anonymous
        send_request(CMD_QRY,  15'h7FFF,   32'h0,          32'h0);
        send_request(CMD_RBND, 15'd0,      32'h0000_0001,  32'h8000_0000);  // rebound
        send_request(CMD_RBND, 15'd0,      32'h22,         32'h33);         // absent
        send_request(CMD_REL,  15'd0,      32'hFFFF_FFFF,  32'h0);          // decrement
        send_request(CMD_REL,  15'd0,      32'hFFFF_FFFF,  32'h0);          // free, move
        for (int c = int'(CMD_QRY) + 1; c <= 7; c++)
            send_request(3'(c), 15'($urandom), $urandom, $urandom);         // spare codes
        send_request(CMD_QRY,  15'h7FFF,   32'h0,          32'h0);
        send_request(CMD_QRY,  15'h0000,   32'h0,          32'h0);          // freed id
        send_request(CMD_REL,  15'd0,      32'hA5A5_A5A5,  32'h0);          // free slot 0
        send_request(CMD_REL,  15'd0,      32'h8000_0000,  32'h0);          // last entry
        send_request(CMD_QRY,  15'h7FFF,   32'h0,          32'h0);          // table empty
    endtask

    // One id acquired past 255 references, then released once.
    task automatic test_count_saturation();
        idle_pct = 10;
        repeat (260)
            send_request(CMD_ACQ, 15'h2AAA, 32'h0, 32'h5A5A_0001);
        send_request(CMD_QRY, 15'h2AAA, 32'h0, 32'h0);
        send_request(CMD_REL, 15'd0, 32'h5A5A_0001, 32'h0);
    endtask

    // Fill to DEPTH, hit the full cases, then drain back to a small table.
    task automatic test_directory_full();
        logic [14:0] id;
        idle_pct = 15;
        while (dir_used < DEPTH) begin
            if ($urandom_range(0, 3) == 0) begin
                send_request(CMD_ANON, 15'($urandom), 32'h0, $urandom | 32'h1);
            end else begin
                do id = 15'($urandom); while (find_by_id(id) != DEPTH);
                send_request(CMD_ACQ, id, 32'h0, $urandom | 32'h1);
            end
        end
        do id = 15'($urandom); while (find_by_id(id) != DEPTH);
        send_request(CMD_ACQ,  id, 32'h0, 32'h1357_9BDF);   // miss when full
        send_request(CMD_ANON, id, 32'h0, 32'h2468_ACE0);   // anonymous when full
        send_request(CMD_ACQ,  15'h2AAA, 32'h0, 32'h0);     // hit still works
        send_request(CMD_QRY,  dir_asset[DEPTH-1][14:0], 32'h0, 32'h0);
        send_request(CMD_REL,  15'd0, 32'h5A5A_0001, 32'h0);
        while (dir_used > 16)
            send_request(CMD_REL, 15'd0, dir_handle[$urandom_range(0, dir_used - 1)],
                         32'h0);
    endtask

    task automatic test_random_traffic(input int n_items, input int pct);
        int         roll;
        logic [2:0] cmd;
        idle_pct = pct;
        repeat (n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                cmd = CMD_ACQ;
            else if (roll < 65)
                cmd = CMD_REL;
            else if (roll < 77)
                cmd = CMD_RBND;
            else if (roll < 85)
                cmd = CMD_ANON;
            else if (roll < 95)
                cmd = CMD_QRY;
            else
                cmd = 3'($urandom_range(int'(CMD_QRY) + 1, 7));
            send_request(cmd, pick_obj_id(), pick_handle(), pick_new_handle());
        end
    endtask

    // ------------------------------------------------------------------
    // Watchdog: ends the run when no transaction moves for too long
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        rx_stall = 0;
        idle_pct = 0;
        errors   = 0;
        dir_used = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_ops();
        test_count_saturation();
        wait_all_results();          // sender holds off until all is back
        test_directory_full();
        test_random_traffic(450, 30);
        test_random_traffic(150, 0);
        test_random_traffic(450, 40);
        test_random_traffic(250, 0); // closing stretch, no idling

        wait_all_results();
        repeat (DEPTH + 20) @(negedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
